FILE: sv/kce_pkg.sv
// ----------------------------------------------------------------------------
// kce_pkg - shared types and codes for the key chord event queue
// Payload structs for the input and result channels, operation codes,
// key codes and fixed constants of the chord collector.
// ----------------------------------------------------------------------------
package kce_pkg;

    // operation codes of an input transaction
    localparam logic [1:0] OP_PRESS = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // key codes held in the queue
    localparam logic [1:0] CODE_NONE  = 2'd0;
    localparam logic [1:0] CODE_KEY0  = 2'd1;
    localparam logic [1:0] CODE_KEY1  = 2'd2;
    localparam logic [1:0] CODE_CHORD = 2'd3;

    // pending mask patterns
    localparam logic [7:0] CHORD_MASK = 8'h03;
    localparam int unsigned KEY0_POS  = 0;
    localparam int unsigned KEY1_POS  = 1;

    // window length after reset, in ticks
    localparam logic [15:0] WINDOW_RESET = 16'd50;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] key_index;
        logic       level;
    } in_item_t;

    typedef struct packed {
        logic       read_valid;
        logic [1:0] read_code;
        logic       not_empty;
        logic [1:0] dropped_codes;
    } out_item_t;

endpackage

FILE: sv/key_chord_event_queue.sv
// ----------------------------------------------------------------------------
// key_chord_event_queue - button chord collector with a key code queue
// Collects key presses over a tick window, turns the mask into key codes
// and queues them in a circular buffer that holds QUEUE_DEPTH-1 codes.
// ----------------------------------------------------------------------------
// Every input transaction (press, tick or read) is accepted whole and yields
// exactly one result transaction in the next cycle, so the block sustains
// one transaction per clock; the input side stalls only while the result
// register is full and the output side stalls. All state updates
// happen in the accepting cycle; the code queue is a single write port memory
// whose read data lands straight in the result register. A window that ends
// with both key 0 and key 1 (plus other keys) queues two codes: the first is
// written at once and the second in the following cycle from a one-entry write
// buffer, which never collides with another push because a new window needs
// a press and a tick before it can end. The queue needs no clearing pass.
module key_chord_event_queue #(
    parameter int QUEUE_DEPTH = 128
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  kce_pkg::in_item_t in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output kce_pkg::out_item_t out_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(QUEUE_DEPTH - 1);

    // code storage
    logic [1:0] queue_mem [QUEUE_DEPTH];

    // control and status registers
    logic [15:0]      window_ticks_reg;
    logic [7:0]       mask_reg, mask_next;
    logic             active_reg, active_next;
    logic [15:0]      count_reg, count_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic             buf_valid_reg, buf_valid_next;
    logic [PTR_W-1:0] buf_addr_reg, buf_addr_next;

    // result registers
    logic             out_valid_reg, out_valid_next;
    logic             rvalid_reg, rvalid_next;
    logic             nempty_reg, nempty_next;
    logic [1:0]       dropped_reg, dropped_next;
    logic [1:0]       rdata_reg;

    // datapath signals
    logic             acc;
    logic             rd_en;
    logic             push_we;
    logic [1:0]       push_code;
    logic             mem_we;
    logic [PTR_W-1:0] mem_addr;
    logic [1:0]       mem_code;
    logic [PTR_W-1:0] tail1, tail2;
    logic             full1, full2;
    logic [15:0]      count_dec;
    logic             want_first, want_second;
    logic [1:0]       first_code;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_POS) ? '0 : p + PTR_W'(1);
    endfunction

    // handshake
    assign in_stall = out_valid_reg && out_stall;
    assign acc      = in_valid && !in_stall;

    // queue pointer lookahead
    assign tail1 = ptr_inc(tail_reg);
    assign tail2 = ptr_inc(tail1);
    assign full1 = (tail1 == head_reg);
    assign full2 = (tail2 == head_reg);
    assign count_dec = (count_reg != 16'd0) ? count_reg - 16'd1 : 16'd0;

    // pick the codes a closing window produces
    always_comb
    begin
        want_first  = 1'b0;
        want_second = 1'b0;
        first_code  = kce_pkg::CODE_NONE;
        if (mask_reg == kce_pkg::CHORD_MASK)
        begin
            want_first = 1'b1;
            first_code = kce_pkg::CODE_CHORD;
        end
        else if (mask_reg[kce_pkg::KEY0_POS])
        begin
            want_first  = 1'b1;
            first_code  = kce_pkg::CODE_KEY0;
            want_second = mask_reg[kce_pkg::KEY1_POS];
        end
        else if (mask_reg[kce_pkg::KEY1_POS])
        begin
            want_first = 1'b1;
            first_code = kce_pkg::CODE_KEY1;
        end
    end

    // process one transaction
    always_comb
    begin
        mask_next      = mask_reg;
        active_next    = active_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        buf_valid_next = 1'b0;
        buf_addr_next  = buf_addr_reg;
        push_we        = 1'b0;
        push_code      = first_code;
        rd_en          = 1'b0;
        dropped_next   = 2'd0;
        if (acc)
        begin
            case (in_data.op)
                kce_pkg::OP_PRESS:
                begin
                    if (in_data.level)
                    begin
                        mask_next = mask_reg | 8'(8'd1 << in_data.key_index);
                        if (!active_reg)
                        begin
                            active_next = 1'b1;
                            count_next  = (window_ticks_reg == 16'd0) ? 16'd1
                                                                      : window_ticks_reg;
                        end
                    end
                end
                kce_pkg::OP_TICK:
                begin
                    if (active_reg)
                    begin
                        count_next = count_dec;
                        if (count_dec == 16'd0)
                        begin
                            mask_next   = 8'd0;
                            active_next = 1'b0;
                            if (want_first)
                            begin
                                if (full1)
                                begin
                                    dropped_next = want_second ? 2'd2 : 2'd1;
                                end
                                else
                                begin
                                    push_we   = 1'b1;
                                    tail_next = tail1;
                                    if (want_second)
                                    begin
                                        if (full2)
                                        begin
                                            dropped_next = 2'd1;
                                        end
                                        else
                                        begin
                                            buf_valid_next = 1'b1;
                                            buf_addr_next  = tail1;
                                            tail_next      = tail2;
                                        end
                                    end
                                end
                            end
                        end
                    end
                end
                kce_pkg::OP_READ:
                begin
                    if (head_reg != tail_reg)
                    begin
                        rd_en     = 1'b1;
                        head_next = ptr_inc(head_reg);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // memory write port: drain the write buffer or take a fresh push
    always_comb
    begin
        mem_we   = push_we || buf_valid_reg;
        mem_addr = buf_valid_reg ? buf_addr_reg : tail_reg;
        mem_code = buf_valid_reg ? kce_pkg::CODE_KEY1 : push_code;
    end

    // result register next values
    always_comb
    begin
        rvalid_next    = rvalid_reg;
        nempty_next    = nempty_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (acc)
        begin
            out_valid_next = 1'b1;
            rvalid_next    = rd_en;
            nempty_next    = (head_next != tail_next);
        end
    end

    // hold state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_ticks_reg <= kce_pkg::WINDOW_RESET;
            mask_reg         <= 8'd0;
            active_reg       <= 1'b0;
            count_reg        <= 16'd0;
            head_reg         <= '0;
            tail_reg         <= '0;
            buf_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
            rvalid_reg       <= 1'b0;
            nempty_reg       <= 1'b0;
            dropped_reg      <= 2'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                window_ticks_reg <= cfg_data;
            end
            mask_reg      <= mask_next;
            active_reg    <= active_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            buf_valid_reg <= buf_valid_next;
            out_valid_reg <= out_valid_next;
            rvalid_reg    <= rvalid_next;
            nempty_reg    <= nempty_next;
            if (acc)
            begin
                dropped_reg <= dropped_next;
            end
        end
    end

    // hold the write buffer address
    always_ff @(posedge clk)
    begin
        buf_addr_reg <= buf_addr_next;
    end

    // code memory, registered read into the result
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            queue_mem[mem_addr] <= mem_code;
        end
        if (rd_en)
        begin
            rdata_reg <= queue_mem[head_reg];
        end
    end

    // drive the result transaction
    assign out_valid              = out_valid_reg;
    assign out_data.read_valid    = rvalid_reg;
    assign out_data.read_code     = rvalid_reg ? rdata_reg : kce_pkg::CODE_NONE;
    assign out_data.not_empty     = nempty_reg;
    assign out_data.dropped_codes = dropped_reg;

    // the buffered second code never meets a fresh push
    a_buf_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        buf_valid_reg |-> !push_we)
        else $error("write buffer drain collides with a new push");

    // a reported drop leaves the queue full
    a_drop_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && dropped_reg != 2'd0) |-> (ptr_inc(tail_reg) == head_reg))
        else $error("codes dropped while the queue has room");

    // a pop advances the head pointer
    a_pop_advances: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> (head_reg != $past(head_reg)) && rvalid_reg)
        else $error("read of a non-empty queue did not pop");

endmodule

FILE: sim/key_chord_event_queue_test.sv
// ----------------------------------------------------------------------------
// key_chord_event_queue_test - self-checking bench for the chord event queue
// Drives press, tick and read transactions through the valid/stall channel,
// predicts every status result from its own copy of the chord mask, window
// timer and code queue, and checks each result in order as it leaves the
// block. Phases vary the window length and the idle and stall patterns.
// ----------------------------------------------------------------------------
module key_chord_event_queue_test;

    localparam int          QUEUE_DEPTH = 128;
    localparam int          QUEUE_SLOTS = QUEUE_DEPTH - 1;
    localparam int          CYCLE_LIMIT = 50000;
    localparam int          HOLD_CYCLES = 200;
    localparam int          MAX_REPORTS = 10;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [15:0]         cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    kce_pkg::in_item_t   in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    kce_pkg::out_item_t  out_data;

    // stimulus and expected results
    kce_pkg::in_item_t   key_events[$];
    kce_pkg::out_item_t  due_status[$];

    // predicted block state
    logic [15:0] window_len = kce_pkg::WINDOW_RESET;
    logic [7:0]  chord_mask = '0;
    logic        window_open = 1'b0;
    logic [15:0] ticks_left = '0;
    logic [1:0]  code_fifo[$];

    // idle control
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    logic        hold_req = 1'b0;
    logic        hold_seen;
    int          hold_left;

    int          failures = 0;
    int          cycles = 0;

    key_chord_event_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // push one code into the predicted queue, return 1 if it was dropped
    function automatic logic [1:0] queue_code(input logic [1:0] code);
        if (code_fifo.size() == QUEUE_SLOTS)
            return 2'd1;
        code_fifo.push_back(code);
        return 2'd0;
    endfunction

    // advance the predicted state by one transaction, return its status
    function automatic kce_pkg::out_item_t advance_chord_state(input kce_pkg::in_item_t item);
        kce_pkg::out_item_t res;
        res = '0;
        case (item.op)
            kce_pkg::OP_PRESS:
            begin
                if (item.level)
                begin
                    chord_mask[item.key_index] = 1'b1;
                    if (!window_open)
                    begin
                        window_open = 1'b1;
                        ticks_left  = (window_len == 16'd0) ? 16'd1 : window_len;
                    end
                end
            end
            kce_pkg::OP_TICK:
            begin
                if (window_open)
                begin
                    if (ticks_left != 16'd0)
                        ticks_left = ticks_left - 16'd1;
                    if (ticks_left == 16'd0)
                    begin
                        if (chord_mask == kce_pkg::CHORD_MASK)
                            res.dropped_codes += queue_code(kce_pkg::CODE_CHORD);
                        else
                        begin
                            if (chord_mask[kce_pkg::KEY0_POS])
                                res.dropped_codes += queue_code(kce_pkg::CODE_KEY0);
                            if (chord_mask[kce_pkg::KEY1_POS])
                                res.dropped_codes += queue_code(kce_pkg::CODE_KEY1);
                        end
                        chord_mask  = '0;
                        window_open = 1'b0;
                    end
                end
            end
            kce_pkg::OP_READ:
            begin
                if (code_fifo.size() != 0)
                begin
                    res.read_valid = 1'b1;
                    res.read_code  = code_fifo.pop_front();
                end
            end
            default:
            begin
            end
        endcase
        res.not_empty = (code_fifo.size() != 0);
        return res;
    endfunction

    // drive input transactions from the feed, predict on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                due_status.push_back(advance_chord_state(in_data));
            if (!in_valid || !in_stall)
            begin
                if (key_events.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_data  <= key_events.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // drive the result stall: random, or a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_seen <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            hold_seen <= hold_req;
            if (hold_req && !hold_seen)
            begin
                hold_left <= HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic report_failure(input string what, input kce_pkg::out_item_t want,
                                  input kce_pkg::out_item_t got);
        failures++;
        if (failures <= MAX_REPORTS)
            $display({"%s: expected valid %0d code %0d not_empty %0d dropped %0d,",
                      " got valid %0d code %0d not_empty %0d dropped %0d"},
                     what, want.read_valid, want.read_code, want.not_empty,
                     want.dropped_codes, got.read_valid, got.read_code,
                     got.not_empty, got.dropped_codes);
    endtask

    // check each result transaction against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_status.size() == 0)
                report_failure("unexpected result", '0, out_data);
            else if (due_status[0].read_valid    !== out_data.read_valid ||
                     due_status[0].read_code     !== out_data.read_code ||
                     due_status[0].not_empty     !== out_data.not_empty ||
                     due_status[0].dropped_codes !== out_data.dropped_codes)
                report_failure("mismatch", due_status.pop_front(), out_data);
            else
                void'(due_status.pop_front());
        end
    end

    // bound the run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("[key_chord_event_queue] ERROR");
            $finish;
        end
    end

    task automatic add_item(input logic [1:0] op, input logic [2:0] key,
                            input logic lvl);
        kce_pkg::in_item_t item;
        item.op        = op;
        item.key_index = key;
        item.level     = lvl;
        key_events.push_back(item);
    endtask

    // press mostly on keys 0 and 1, mostly with the pin high
    task automatic add_press();
        logic [2:0] key;
        logic       lvl;
        key = ($urandom_range(99) < 75) ? 3'($urandom_range(1)) : 3'($urandom_range(7));
        lvl = ($urandom_range(99) < 90);
        add_item(kce_pkg::OP_PRESS, key, lvl);
    endtask

    // one chord: a few presses, the window's ticks and some reads
    task automatic add_chord(input logic [15:0] win, input int max_reads);
        int presses;
        int ticks;
        int reads;
        presses = int'($urandom_range(1, 3));
        ticks   = ((win == 16'd0) ? 1 : int'(win)) + int'($urandom_range(0, 2));
        reads   = int'($urandom_range(0, max_reads));
        repeat (presses)
            add_press();
        repeat (ticks)
        begin
            add_item(kce_pkg::OP_TICK, 3'($urandom_range(7)), 1'($urandom_range(1)));
            if ($urandom_range(99) < 10)
                add_press();
        end
        repeat (reads)
            add_item(kce_pkg::OP_READ, 3'($urandom_range(7)), 1'($urandom_range(1)));
    endtask

    task automatic add_noise();
        add_item(2'($urandom_range(3)), 3'($urandom_range(7)), 1'($urandom_range(1)));
    endtask

    // hold until all items are sent and every result has been checked
    task automatic wait_idle();
        do
            @(negedge clk);
        while (key_events.size() != 0 || in_valid || due_status.size() != 0);
        repeat (3)
            @(negedge clk);
    endtask

    task automatic write_window(input logic [15:0] value);
        @(posedge clk);
        cfg_we     <= 1'b1;
        cfg_data   <= value;
        window_len  = value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_phase(input logic [15:0] win, input int send_pct,
                             input int stall_in, input int n_items,
                             input int max_reads);
        wait_idle();
        write_window(win);
        send_idle_pct = send_pct;
        stall_pct     = stall_in;
        while (key_events.size() < n_items)
        begin
            if ($urandom_range(99) < 15)
                add_noise();
            else
                add_chord(win, max_reads);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset window: empty read, unused op, ignored press, idle tick
        add_item(kce_pkg::OP_READ, 3'd0, 1'b0);
        add_item(OP_UNUSED, 3'd7, 1'b1);
        add_item(kce_pkg::OP_PRESS, 3'd1, 1'b0);
        add_item(kce_pkg::OP_TICK, 3'd7, 1'b1);

        // zero window acts as one tick: single keys, chord, extra keys
        wait_idle();
        write_window(16'd0);
        add_item(kce_pkg::OP_PRESS, 3'd0, 1'b1);
        add_item(kce_pkg::OP_TICK, 3'd0, 1'b0);
        add_item(kce_pkg::OP_PRESS, 3'd1, 1'b1);
        add_item(kce_pkg::OP_TICK, 3'd5, 1'b1);
        add_item(kce_pkg::OP_PRESS, 3'd0, 1'b1);
        add_item(kce_pkg::OP_PRESS, 3'd1, 1'b1);
        add_item(kce_pkg::OP_TICK, 3'd0, 1'b0);
        add_item(kce_pkg::OP_PRESS, 3'd0, 1'b1);
        add_item(kce_pkg::OP_PRESS, 3'd1, 1'b1);
        add_item(kce_pkg::OP_PRESS, 3'd2, 1'b1);
        add_item(kce_pkg::OP_TICK, 3'd0, 1'b0);
        add_item(kce_pkg::OP_PRESS, 3'd7, 1'b1);
        add_item(kce_pkg::OP_TICK, 3'd0, 1'b0);
        repeat (5)
            add_item(kce_pkg::OP_READ, 3'd7, 1'b1);

        // later presses do not restart a running window
        wait_idle();
        write_window(16'd3);
        add_item(kce_pkg::OP_PRESS, 3'd0, 1'b1);
        add_item(kce_pkg::OP_TICK, 3'd0, 1'b0);
        add_item(kce_pkg::OP_PRESS, 3'd1, 1'b1);
        add_item(kce_pkg::OP_TICK, 3'd0, 1'b0);
        add_item(kce_pkg::OP_TICK, 3'd0, 1'b0);
        add_item(kce_pkg::OP_READ, 3'd0, 1'b0);

        // no idling, with a long receiver hold-off to back up the input
        run_phase(16'd2, 0, 0, 30, 3);
        hold_req = 1'b1;

        // sender idle
        run_phase(16'($urandom_range(1, 5)), 68, 0, 30, 3);
        hold_req = 1'b0;

        // receiver stalling: two codes per window fill the queue past full
        wait_idle();
        write_window(16'd1);
        send_idle_pct = 0;
        stall_pct     = 68;
        repeat (65)
        begin
            add_item(kce_pkg::OP_PRESS, 3'd0, 1'b1);
            add_item(kce_pkg::OP_PRESS, 3'd1, 1'b1);
            add_item(kce_pkg::OP_PRESS, 3'($urandom_range(2, 7)), 1'b1);
            add_item(kce_pkg::OP_TICK, 3'd0, 1'b0);
        end
        // drain it, ending with an empty read
        repeat (130)
            add_item(kce_pkg::OP_READ, 3'($urandom_range(7)), 1'($urandom_range(1)));

        // both sides idling, default window length and a short one
        run_phase(kce_pkg::WINDOW_RESET, 16, 16, 40, 2);
        run_phase(16'd3, 16, 16, 20, 3);

        wait_idle();
        repeat (10)
            @(negedge clk);
        if (failures == 0 && due_status.size() == 0)
            $display("[key_chord_event_queue] OK");
        else
            $display("[key_chord_event_queue] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
sv/kce_pkg.sv
sv/key_chord_event_queue.sv
sim/key_chord_event_queue_test.sv
